// File: design/bac_pkg.sv
// Shared types, mode codes and BCD time helpers for the BCD alarm clock.
package bac_pkg;

    localparam int TIME_DIGITS = 6;
    localparam int TIME_W      = 4 * TIME_DIGITS;
    localparam int TPS_W       = 16;
    localparam int MIN_W       = 8;

    localparam logic [2:0] MODE_TICK     = 3'd0;
    localparam logic [2:0] MODE_SET_TIME = 3'd1;
    localparam logic [2:0] MODE_SET_ALRM = 3'd2;
    localparam logic [2:0] MODE_ENABLE   = 3'd3;
    localparam logic [2:0] MODE_POSTPONE = 3'd4;
    localparam logic [2:0] MODE_CANCEL   = 3'd5;

    // Step size selector for the shared BCD incrementer.
    localparam logic STEP_SECOND = 1'b0;
    localparam logic STEP_MINUTE = 1'b1;

    localparam logic [TPS_W-1:0] TPS_RESET = 16'd1000;

    typedef struct packed {
        logic [2:0]        mode;
        logic [TIME_W-1:0] time_bcd;
        logic              enable_value;
        logic [MIN_W-1:0]  postpone_minutes;
    } t_in_item;

    typedef struct packed {
        logic              half_second;
        logic              alarm_ringing;
        logic              set_accepted;
        logic [TIME_W-1:0] current_time;
        logic              time_is_valid;
        logic [TIME_W-1:0] alarm_time;
        logic              alarm_is_valid;
        logic              alarm_is_enabled;
    } t_out_item;

    // True when every digit is decimal and the value is a time of day.
    function automatic logic bcd_valid(input logic [TIME_W-1:0] v);
        logic ok;
        ok = 1'b1;
        for (int i = 0; i < TIME_DIGITS; i++) begin
            if (v[4*i +: 4] > 4'd9) begin
                ok = 1'b0;
            end
        end
        if (v[23:20] > 4'd2) ok = 1'b0;
        if (v[23:20] == 4'd2 && v[19:16] > 4'd3) ok = 1'b0;
        if (v[15:12] > 4'd5) ok = 1'b0;
        if (v[7:4] > 4'd5) ok = 1'b0;
        return ok;
    endfunction

endpackage

// File: design/bac_step_unit.sv
// Shared BCD incrementer: adds one second or one minute to an HHMMSS time.
module bac_step_unit
    import bac_pkg::*;
(
    input  logic [TIME_W-1:0] i_value,
    input  logic              i_unit,
    output logic [TIME_W-1:0] o_value
);

    logic [3:0] s0, s1, m0, m1, h0, h1;
    logic [3:0] q0, q1, p0, p1, g0, g1;
    logic       c_s0, c_s1, c_m0, c_m1;

    assign {h1, h0, m1, m0, s1, s0} = i_value;

    always_comb begin
        // Seconds take part only for a one-second step.
        c_s0 = (i_unit == STEP_SECOND) && (s0 == 4'd9);
        c_s1 = c_s0 && (s1 == 4'd5);
        q0   = s0;
        q1   = s1;
        if (i_unit == STEP_SECOND) begin
            q0 = c_s0 ? 4'd0 : s0 + 4'd1;
            if (c_s0) q1 = c_s1 ? 4'd0 : s1 + 4'd1;
        end

        // Minutes move on a seconds carry or directly for a minute step.
        c_m0 = ((i_unit == STEP_MINUTE) || c_s1) && (m0 == 4'd9);
        c_m1 = c_m0 && (m1 == 4'd5);
        p0   = m0;
        p1   = m1;
        if ((i_unit == STEP_MINUTE) || c_s1) begin
            p0 = c_m0 ? 4'd0 : m0 + 4'd1;
            if (c_m0) p1 = c_m1 ? 4'd0 : m1 + 4'd1;
        end

        g0 = h0;
        g1 = h1;
        if (c_m1) begin
            if (h1 == 4'd2 && h0 == 4'd3) begin
                g0 = 4'd0;
                g1 = 4'd0;
            end else if (h0 == 4'd9) begin
                g0 = 4'd0;
                g1 = h1 + 4'd1;
            end else begin
                g0 = h0 + 4'd1;
            end
        end
    end

    assign o_value = {g1, g0, p1, p0, q1, q0};

endmodule

// File: design/bcd_alarm_clock.sv
// Top level of the BCD alarm clock: APB register, item sequencer and state.
//
// Usage: each input item carries a mode (tick, set time, set alarm, enable,
// postpone, cancel) plus its operands, and produces exactly one result item
// that reports the time, the alarm and the status flags after the item.
// The input channel is ready only while the sequencer is idle; one item is
// worked on at a time. A simple item passes an execute step and a result step,
// and its result is loaded into the output register from the result step. A
// tick that completes a second also passes a second step and a compare step:
// it runs the shared BCD incrementer once and then compares the alarm. A
// postpone of N minutes stays in a minute step while the same incrementer adds
// one minute per cycle to the snooze time.
// The result sits in an output register; a new item is accepted while it
// waits, but the sequencer holds in its final step until the output register
// is free, so a stalled receiver eventually stalls the input.
// ticks_per_second is written at APB address 0; the user must write it only while
// the block is idle, which the block does not enforce. Synchronous reset clears
// the time, alarm, flags and prescaler count, and sets ticks_per_second to 1000.
module bcd_alarm_clock
    import bac_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_item,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_SEC  = 3'd2;
    localparam logic [2:0] S_CHK  = 3'd3;
    localparam logic [2:0] S_MIN  = 3'd4;
    localparam logic [2:0] S_RES  = 3'd5;

    localparam logic [1:0] ADDR_TPS = 2'd0;

    logic [2:0]        r_state, n_state;
    t_in_item          r_item, n_item;
    logic [TPS_W-1:0]  r_tps;
    logic [TPS_W-1:0]  r_cnt, n_cnt;
    logic [TIME_W-1:0] r_time, n_time;
    logic [TIME_W-1:0] r_alarm, n_alarm;
    logic [TIME_W-1:0] r_snooze, n_snooze;
    logic              r_time_set, n_time_set;
    logic              r_alarm_set, n_alarm_set;
    logic              r_alarm_en, n_alarm_en;
    logic              r_snoozing, n_snoozing;
    logic              r_ringing, n_ringing;
    logic              r_accepted, n_accepted;
    logic [MIN_W-1:0]  r_min_left, n_min_left;
    logic              r_out_valid, n_out_valid;
    t_out_item         r_out, n_out;

    logic [TPS_W-1:0]  cnt_inc;
    logic              tb_valid;
    logic [TIME_W-1:0] step_in, step_out;
    logic              step_unit;
    logic              cfg_write;

    // The single BCD incrementer serves both the second advance of the time
    // and the minute steps of the snooze time.
    assign step_in   = (r_state == S_MIN) ? r_snooze : r_time;
    assign step_unit = (r_state == S_MIN) ? STEP_MINUTE : STEP_SECOND;

    bac_step_unit u_step (
        .i_value (step_in),
        .i_unit  (step_unit),
        .o_value (step_out)
    );

    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;
    assign prdata    = (paddr == ADDR_TPS) ? {16'd0, r_tps} : 32'd0;

    assign cnt_inc  = r_cnt + 16'd1;
    assign tb_valid = bcd_valid(r_item.time_bcd);

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_cnt       = r_cnt;
        n_time      = r_time;
        n_alarm     = r_alarm;
        n_snooze    = r_snooze;
        n_time_set  = r_time_set;
        n_alarm_set = r_alarm_set;
        n_alarm_en  = r_alarm_en;
        n_snoozing  = r_snoozing;
        n_ringing   = r_ringing;
        n_accepted  = r_accepted;
        n_min_left  = r_min_left;
        n_out_valid = r_out_valid;
        n_out       = r_out;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_item  = i_in_item;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_accepted = 1'b0;
                n_state    = S_RES;
                unique case (r_item.mode)
                    MODE_TICK: begin
                        if (cnt_inc >= r_tps) begin
                            n_cnt   = '0;
                            n_state = S_SEC;
                        end else begin
                            n_cnt = cnt_inc;
                        end
                    end
                    MODE_SET_TIME: begin
                        n_time_set = tb_valid;
                        n_accepted = tb_valid;
                        if (tb_valid) n_time = r_item.time_bcd;
                    end
                    MODE_SET_ALRM: begin
                        n_alarm_set = tb_valid;
                        n_alarm_en  = tb_valid;
                        n_accepted  = tb_valid;
                        if (tb_valid) n_alarm = r_item.time_bcd;
                    end
                    MODE_ENABLE: begin
                        n_alarm_en = r_item.enable_value;
                    end
                    MODE_POSTPONE: begin
                        // The alarm is copied only when a postponement starts.
                        if (!r_snoozing) begin
                            n_snooze   = r_alarm;
                            n_snoozing = 1'b1;
                            n_ringing  = 1'b0;
                        end
                        n_min_left = r_item.postpone_minutes;
                        n_state    = S_MIN;
                    end
                    MODE_CANCEL: begin
                        n_ringing = 1'b0;
                    end
                    default: begin
                    end
                endcase
            end
            S_SEC: begin
                n_time  = step_out;
                n_state = S_CHK;
            end
            S_CHK: begin
                if (r_alarm_en && !r_snoozing && r_time == r_alarm) begin
                    n_ringing = 1'b1;
                end
                if (r_alarm_en && r_snoozing && r_time == r_snooze) begin
                    n_ringing  = 1'b1;
                    n_snoozing = 1'b0;
                end
                n_state = S_RES;
            end
            S_MIN: begin
                if (r_min_left == '0) begin
                    n_state = S_RES;
                end else begin
                    n_snooze   = step_out;
                    n_min_left = r_min_left - 8'd1;
                end
            end
            S_RES: begin
                // Wait here until the output register is free.
                if (!r_out_valid || i_out_ready) begin
                    n_out.half_second      = (r_item.mode == MODE_TICK) &&
                                             (r_cnt >= (r_tps >> 1));
                    n_out.alarm_ringing    = r_ringing;
                    n_out.set_accepted     = r_accepted;
                    n_out.current_time     = r_time;
                    n_out.time_is_valid    = r_time_set;
                    n_out.alarm_time       = r_alarm;
                    n_out.alarm_is_valid   = r_alarm_set;
                    n_out.alarm_is_enabled = r_alarm_en;
                    n_out_valid            = 1'b1;
                    n_state                = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tps       <= TPS_RESET;
            r_cnt       <= '0;
            r_time      <= '0;
            r_alarm     <= '0;
            r_snooze    <= '0;
            r_time_set  <= 1'b0;
            r_alarm_set <= 1'b0;
            r_alarm_en  <= 1'b0;
            r_snoozing  <= 1'b0;
            r_ringing   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_time      <= n_time;
            r_alarm     <= n_alarm;
            r_snooze    <= n_snooze;
            r_time_set  <= n_time_set;
            r_alarm_set <= n_alarm_set;
            r_alarm_en  <= n_alarm_en;
            r_snoozing  <= n_snoozing;
            r_ringing   <= n_ringing;
            r_out_valid <= n_out_valid;
            if (cfg_write && paddr == ADDR_TPS) begin
                r_tps <= pwdata[TPS_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_item     <= n_item;
        r_accepted <= n_accepted;
        r_min_left <= n_min_left;
        r_out      <= n_out;
    end

    // The alarm starts ringing only from the compare step after a second.
    a_ring_from_chk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ringing) |-> $past(r_state) == S_CHK)
        else $error("alarm started ringing outside the compare step");

    // A postponement ends only when the snooze time is matched.
    a_snooze_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_snoozing) |-> $past(r_state) == S_CHK)
        else $error("snooze ended outside the compare step");

    // The time changes only by a second step or an accepted set-time item.
    a_time_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_time != $past(r_time)) |->
            ($past(r_state) == S_SEC ||
             ($past(r_state) == S_EXEC && $past(r_item.mode) == MODE_SET_TIME)))
        else $error("time changed without a second step or set-time item");

    // A result appears only from the final sequencer step.
    a_out_from_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == S_RES)
        else $error("result loaded outside the final step");

endmodule

// File: tb/bcd_alarm_clock_check.sv
// Checker for the BCD alarm clock: predicts every result item and compares it with the block.
module bcd_alarm_clock_check
    import bac_pkg::*;
#(
    parameter logic [1:0] RATE_ADDR = 2'd0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  t_in_item          i_in_item,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  t_out_item         i_out_item,
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic              i_pready,
    input  logic [1:0]        i_paddr,
    input  logic [31:0]       i_pwdata,
    output int                o_fail_count,
    output int                o_pending,
    output int                o_checked,
    output int                o_rings,
    output logic              o_snoozing,
    output logic [TIME_W-1:0] o_snooze_bcd
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned SECS_PER_DAY = 86400;

    // Predicted clock state.
    logic [TPS_W-1:0]  rate;
    logic [TPS_W-1:0]  prescale;
    logic [TIME_W-1:0] now_bcd;
    logic [TIME_W-1:0] alarm_bcd;
    logic [TIME_W-1:0] doze_bcd;
    logic              now_set;
    logic              alarm_set;
    logic              alarm_on;
    logic              dozing;
    logic              ring;

    t_out_item due_reports[$];
    t_out_item want;
    t_out_item got;
    logic      rang_before;

    function automatic int unsigned day_secs(input logic [TIME_W-1:0] v);
        int unsigned hh;
        int unsigned mm;
        int unsigned ss;
        hh = v[23:20] * 10 + v[19:16];
        mm = v[15:12] * 10 + v[11:8];
        ss = v[7:4] * 10 + v[3:0];
        return (hh * 3600 + mm * 60 + ss) % SECS_PER_DAY;
    endfunction

    function automatic logic [TIME_W-1:0] day_bcd(input int unsigned t);
        int unsigned hh;
        int unsigned mm;
        int unsigned ss;
        hh = t / 3600;
        mm = (t / 60) % 60;
        ss = t % 60;
        return TIME_W'(((hh / 10) << 20) | ((hh % 10) << 16) | ((mm / 10) << 12) |
                       ((mm % 10) << 8) | ((ss / 10) << 4) | (ss % 10));
    endfunction

    // A time of day: decimal digits, hours up to 23, tens of minutes and seconds up to 5.
    function automatic logic clock_ok(input logic [TIME_W-1:0] v);
        logic ok;
        ok = 1'b1;
        for (int d = 0; d < TIME_DIGITS; d++) begin
            if (v[4*d +: 4] > 4'd9) ok = 1'b0;
        end
        if (v[23:20] * 10 + v[19:16] > 23) ok = 1'b0;
        if (v[15:12] > 4'd5 || v[7:4] > 4'd5) ok = 1'b0;
        return ok;
    endfunction

    // Applies one input item to the predicted state and returns the result it causes.
    function automatic t_out_item clock_step(input t_in_item it);
        t_out_item r;
        int unsigned later;
        r = '0;
        case (it.mode)
            MODE_TICK: begin
                prescale = prescale + 1'b1;
                if (prescale >= rate) begin
                    prescale = '0;
                    now_bcd = day_bcd((day_secs(now_bcd) + 1) % SECS_PER_DAY);
                    if (alarm_on && !dozing && now_bcd == alarm_bcd) ring = 1'b1;
                    if (alarm_on && dozing && now_bcd == doze_bcd) begin
                        ring = 1'b1;
                        dozing = 1'b0;
                    end
                end
                r.half_second = (prescale >= (rate >> 1));
            end
            MODE_SET_TIME: begin
                now_set = clock_ok(it.time_bcd);
                if (now_set) now_bcd = it.time_bcd;
                r.set_accepted = now_set;
            end
            MODE_SET_ALRM: begin
                alarm_set = clock_ok(it.time_bcd);
                alarm_on = alarm_set;
                if (alarm_set) alarm_bcd = it.time_bcd;
                r.set_accepted = alarm_set;
            end
            MODE_ENABLE: begin
                alarm_on = it.enable_value;
            end
            MODE_POSTPONE: begin
                // The first postpone starts from the alarm; later ones extend the snooze.
                if (!dozing) begin
                    doze_bcd = alarm_bcd;
                    dozing = 1'b1;
                    ring = 1'b0;
                end
                later = day_secs(doze_bcd) + it.postpone_minutes * 60;
                doze_bcd = day_bcd(later % SECS_PER_DAY);
            end
            MODE_CANCEL: begin
                ring = 1'b0;
            end
            default: ;
        endcase
        r.alarm_ringing    = ring;
        r.current_time     = now_bcd;
        r.time_is_valid    = now_set;
        r.alarm_time       = alarm_bcd;
        r.alarm_is_valid   = alarm_set;
        r.alarm_is_enabled = alarm_on;
        return r;
    endfunction

    task automatic compare_field(input string label, input logic [TIME_W-1:0] want_v,
                                 input logic [TIME_W-1:0] got_v);
        if (want_v !== got_v) begin
            $error("%s: expected %h, got %h", label, want_v, got_v);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rate         = TPS_RESET;
            prescale     = '0;
            now_bcd      = '0;
            alarm_bcd    = '0;
            doze_bcd     = '0;
            now_set      = 1'b0;
            alarm_set    = 1'b0;
            alarm_on     = 1'b0;
            dozing       = 1'b0;
            ring         = 1'b0;
            o_fail_count = 0;
            o_checked    = 0;
            o_rings      = 0;
            due_reports.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == RATE_ADDR) begin
                rate = i_pwdata[TPS_W-1:0];
            end
            if (i_in_valid && i_in_ready) begin
                rang_before = ring;
                due_reports.push_back(clock_step(i_in_item));
                if (ring && !rang_before) o_rings++;
            end
            if (i_out_valid && i_out_ready) begin
                got = i_out_item;
                if (due_reports.size() == 0) begin
                    $error("result item %h arrived with nothing pending", got);
                    o_fail_count++;
                end else begin
                    want = due_reports.pop_front();
                    compare_field("half_second", TIME_W'(want.half_second),
                                  TIME_W'(got.half_second));
                    compare_field("alarm_ringing", TIME_W'(want.alarm_ringing),
                                  TIME_W'(got.alarm_ringing));
                    compare_field("set_accepted", TIME_W'(want.set_accepted),
                                  TIME_W'(got.set_accepted));
                    compare_field("current_time", want.current_time, got.current_time);
                    compare_field("time_is_valid", TIME_W'(want.time_is_valid),
                                  TIME_W'(got.time_is_valid));
                    compare_field("alarm_time", want.alarm_time, got.alarm_time);
                    compare_field("alarm_is_valid", TIME_W'(want.alarm_is_valid),
                                  TIME_W'(got.alarm_is_valid));
                    compare_field("alarm_is_enabled", TIME_W'(want.alarm_is_enabled),
                                  TIME_W'(got.alarm_is_enabled));
                    o_checked++;
                end
            end
        end
        o_pending    = due_reports.size();
        o_snoozing   = dozing;
        o_snooze_bcd = doze_bcd;
    end

endmodule

// File: tb/testbench.sv
// Top of the BCD alarm clock testbench: clock, reset, stimulus, watchdog and verdict.
module testbench
    import bac_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    // The two mode codes the block leaves unused.
    localparam logic [2:0] MODE_SPARE_6 = 3'd6;
    localparam logic [2:0] MODE_SPARE_7 = 3'd7;

    // The single configuration register sits at byte address zero.
    localparam logic [1:0] RATE_ADDR = 2'd0;

    localparam int IDLE_PCT       = 7;
    localparam int RESET_CYCLES   = 12;
    localparam int STALL_CYCLES   = 500;
    localparam int SETTLE_CYCLES  = 8;
    localparam int DRAIN_CYCLES   = 20;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PHASE_ITEMS    = 120;
    localparam int NUM_PHASES     = 11;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              in_valid;
    logic              in_ready;
    t_in_item          in_item;
    logic              out_valid;
    logic              out_ready;
    t_out_item         out_item;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [1:0]        paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    int                fail_count;
    int                pending;
    int                checked;
    int                rings;
    logic              doze_hint;
    logic [TIME_W-1:0] doze_at;

    // Knobs shared by the sender and receiver processes.
    logic              idle_on;
    logic              long_stall;
    logic              stall_done;

    int                items_sent;
    int                tick_items;
    int                set_items;
    int                postpone_items;
    int                rates_used;
    int                quiet_cycles;

    logic [TPS_W-1:0]  phase_rates [NUM_PHASES] = '{16'd1, 16'd2, 16'd1, 16'd3, 16'd4,
                                                    16'd65535, 16'd1, 16'd0, 16'd2, 16'd9,
                                                    16'd1};

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    bcd_alarm_clock DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // The checker follows both channels and the register writes on its own.
    bcd_alarm_clock_check #(.RATE_ADDR(RATE_ADDR)) clock_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_item   (out_item),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_rings      (rings),
        .o_snoozing   (doze_hint),
        .o_snooze_bcd (doze_at)
    );

    // Packs hours, minutes and seconds into the six BCD digits the block uses.
    function automatic logic [TIME_W-1:0] pack_hms(input int unsigned hh, input int unsigned mm,
                                                   input int unsigned ss);
        return TIME_W'(((hh / 10) << 20) | ((hh % 10) << 16) | ((mm / 10) << 12) |
                       ((mm % 10) << 8) | ((ss / 10) << 4) | (ss % 10));
    endfunction

    function automatic logic [TIME_W-1:0] any_clock();
        return pack_hms($urandom_range(0, 23), $urandom_range(0, 59), $urandom_range(0, 59));
    endfunction

    // An item of the given mode with every field it does not use filled with noise.
    function automatic t_in_item noisy(input logic [2:0] mode);
        t_in_item it;
        it.mode             = mode;
        it.time_bcd         = TIME_W'($urandom_range(0, (1 << TIME_W) - 1));
        it.enable_value     = 1'($urandom_range(0, 1));
        it.postpone_minutes = MIN_W'($urandom_range(0, (1 << MIN_W) - 1));
        return it;
    endfunction

    // One random operation, weighted towards ticks so that the alarm gets a chance to ring.
    // Sets are half valid clock values and half raw 24-bit noise, and postpones are mostly
    // short so the snooze comes around again within a scenario.
    function automatic t_in_item random_op();
        t_in_item    it;
        int unsigned roll;
        int unsigned span;
        roll = $urandom_range(0, 99);
        if (roll < 62) begin
            it = noisy(MODE_TICK);
        end else if (roll < 66) begin
            it = noisy(MODE_SET_TIME);
            if ($urandom_range(0, 1) == 1) it.time_bcd = any_clock();
        end else if (roll < 70) begin
            it = noisy(MODE_SET_ALRM);
            if ($urandom_range(0, 1) == 1) it.time_bcd = any_clock();
        end else if (roll < 77) begin
            it = noisy(MODE_ENABLE);
            it.enable_value = ($urandom_range(0, 3) != 0);
        end else if (roll < 85) begin
            it = noisy(MODE_POSTPONE);
            span = $urandom_range(0, 99);
            if (span < 80) begin
                it.postpone_minutes = MIN_W'($urandom_range(0, 2));
            end else if (span < 95) begin
                it.postpone_minutes = MIN_W'($urandom_range(3, 59));
            end else begin
                it.postpone_minutes = MIN_W'($urandom_range(0, 255));
            end
        end else if (roll < 96) begin
            it = noisy(MODE_CANCEL);
        end else begin
            it = noisy($urandom_range(0, 1) == 1 ? MODE_SPARE_6 : MODE_SPARE_7);
        end
        return it;
    endfunction

    // Offers one item and returns at the falling edge after it is accepted. Valid is only
    // lowered inside an idle gap, so back-to-back items keep it high without a glitch.
    task automatic send(input t_in_item it);
        while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge i_clk); while (!in_ready);
        @(negedge i_clk);
        items_sent++;
        case (it.mode)
            MODE_TICK:                    tick_items++;
            MODE_SET_TIME, MODE_SET_ALRM: set_items++;
            MODE_POSTPONE:                postpone_items++;
            default: ;
        endcase
    endtask

    task automatic issue(input logic [2:0] mode, input logic [TIME_W-1:0] t, input logic en,
                         input logic [MIN_W-1:0] mins);
        t_in_item it;
        it.mode             = mode;
        it.time_bcd         = t;
        it.enable_value     = en;
        it.postpone_minutes = mins;
        send(it);
    endtask

    // Changes ticks_per_second. The block must be idle, so every result is collected first
    // and the sequencer is left to settle before the APB write.
    task automatic set_rate(input logic [TPS_W-1:0] r);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= RATE_ADDR;
        pwdata  <= {{(32 - TPS_W){1'b0}}, r};
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        rates_used++;
    endtask

    // A well-formed scenario: place the time just ahead of an alarm (or of the pending
    // snooze), then let random operations run so that the alarm rings, gets postponed,
    // rings again from the snooze, or gets cancelled. One in five alarms sits just after
    // midnight with the time a few seconds before it, so the day wrap is crossed.
    task automatic scenario();
        t_in_item          it;
        logic [TIME_W-1:0] wake;
        logic [TIME_W-1:0] start;
        int unsigned       ops;
        if (doze_hint && $urandom_range(0, 1) == 1) begin
            it = noisy(MODE_SET_TIME);
            it.time_bcd = {doze_at[23:8], 8'h00};
            send(it);
        end else begin
            if ($urandom_range(0, 4) == 0) begin
                wake  = pack_hms(0, 0, $urandom_range(0, 9));
                start = 24'h235955;
            end else begin
                wake  = pack_hms($urandom_range(0, 23), $urandom_range(0, 59),
                                 $urandom_range(0, 15));
                start = {wake[23:8], 8'h00};
            end
            it = noisy(MODE_SET_ALRM);
            it.time_bcd = wake;
            send(it);
            it = noisy(MODE_SET_TIME);
            it.time_bcd = start;
            send(it);
        end
        ops = $urandom_range(15, 60);
        repeat (ops) send(random_op());
    endtask

    // Receiver: random backpressure, plus one long hold-off on request from the sender.
    initial begin
        out_ready  = 1'b0;
        stall_done = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_stall && !stall_done) begin
                out_ready <= 1'b0;
                repeat (STALL_CYCLES) @(negedge i_clk);
                stall_done = 1'b1;
            end
            out_ready <= !idle_on || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Watchdog: the run is stuck if neither channel moves an item for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quiet_cycles = 0;
        end else if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no item moved for %0d cycles", quiet_cycles);
                $display("bcd_alarm_clock regression: fail");
                $finish;
            end
        end
    end

    // Stimulus: directed checks first, then random scenarios over a range of tick rates.
    initial begin
        i_rst_n        = 1'b0;
        in_valid       = 1'b0;
        in_item        = '0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        idle_on        = 1'b1;
        long_stall     = 1'b0;
        items_sent     = 0;
        tick_items     = 0;
        set_items      = 0;
        postpone_items = 0;
        rates_used     = 0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset rate of 1000: a tick only moves the prescaler and half_second stays low.
        issue(MODE_TICK, '0, 1'b0, '0);
        issue(MODE_SPARE_6, '1, 1'b1, '1);
        // Enabling before any alarm was set is allowed; the stored zero is compared.
        issue(MODE_ENABLE, '0, 1'b1, '0);
        // Rejected sets: hour 24, seconds 60, all digits above nine.
        issue(MODE_SET_TIME, 24'h240000, 1'b0, '0);
        issue(MODE_SET_TIME, 24'h235960, 1'b0, '0);
        issue(MODE_SET_TIME, 24'hFFFFFF, 1'b0, '0);
        issue(MODE_SET_TIME, 24'h235959, 1'b0, '0);
        issue(MODE_SET_ALRM, 24'h000000, 1'b0, '0);
        // A rejected alarm clears both alarm flags but keeps the stored value.
        issue(MODE_SET_ALRM, 24'h006000, 1'b0, '0);
        issue(MODE_SET_ALRM, 24'h000001, 1'b0, '0);
        // The first postpone copies the alarm, the second extends it past 04:00.
        issue(MODE_POSTPONE, '0, 1'b0, 8'd0);
        issue(MODE_POSTPONE, '0, 1'b0, 8'd255);
        issue(MODE_CANCEL, '0, 1'b0, '0);

        // One tick per second: each tick is a full second, and the second pair crosses midnight.
        set_rate(16'd1);
        issue(MODE_SET_TIME, 24'h041559, 1'b0, '0);
        issue(MODE_TICK, '0, 1'b0, '0);
        issue(MODE_TICK, '0, 1'b0, '0);
        issue(MODE_CANCEL, '0, 1'b0, '0);
        issue(MODE_SET_ALRM, 24'h000000, 1'b0, '0);
        issue(MODE_SET_TIME, 24'h235958, 1'b0, '0);
        issue(MODE_TICK, '0, 1'b0, '0);
        issue(MODE_TICK, '0, 1'b0, '0);

        // Largest rate, then a rate below the count: the next tick wraps the prescaler.
        set_rate(16'd65535);
        issue(MODE_TICK, '0, 1'b0, '0);
        issue(MODE_TICK, '0, 1'b0, '0);
        issue(MODE_TICK, '0, 1'b0, '0);
        set_rate(16'd2);
        issue(MODE_TICK, '0, 1'b0, '0);

        // Zero ticks per second: every tick is a full second and half_second is high.
        set_rate(16'd0);
        issue(MODE_TICK, '0, 1'b0, '0);

        // Random part. The third phase runs without any idling; the fourth starts with a
        // long receiver hold-off while items keep coming, so the block backs up.
        for (int p = 0; p < NUM_PHASES; p++) begin
            set_rate(phase_rates[p]);
            idle_on = (p != 2);
            if (p == 3) long_stall = 1'b1;
            while (items_sent < (p + 1) * PHASE_ITEMS) scenario();
        end

        // Let every outstanding result drain; the watchdog bounds this wait.
        in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Sent %0d items: %0d ticks, %0d time or alarm sets, %0d postpones, at %0d rates.",
                 items_sent, tick_items, set_items, postpone_items, rates_used);
        $display("Compared %0d results field by field; the alarm started ringing %0d times.",
                 checked, rings);
        if (fail_count == 0) begin
            $display("bcd_alarm_clock regression: pass");
        end else begin
            $display("bcd_alarm_clock regression: fail");
        end
        $finish;
    end

endmodule
